>>> rtl/core/gsfp_pkg.sv
// Shared constants, register indexes, sequencer op codes and command struct
// for the gait scheduler and foothold planner. No dependencies.
package gsfp_pkg;

	localparam int LEG_COUNT_DEF = 4;
	localparam int OFFSET_SLOTS  = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_GAIT_PERIOD     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWING_COUNT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTER_STEP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSETS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_GAIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_SWING_TIME = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_X         = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Y         = 3'd7;

	localparam logic [15:0] GAIT_PERIOD_RST  = 16'd120;
	localparam logic [15:0] SWING_COUNT_RST  = 16'd60;
	localparam logic [15:0] COUNTER_STEP_RST = 16'd1;

	// phase sum width and remainder iteration counter width
	localparam int SUM_W     = 17;
	localparam int DIV_CNT_W = 5;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CX,
		OP_SY,
		OP_CY,
		OP_SX,
		OP_BY,
		OP_DX,
		OP_GX,
		OP_HX,
		OP_GY,
		OP_HY,
		OP_FY,
		OP_OY
	} op_t;

	typedef struct packed {
		logic load_in;
		op_t  op;
		logic leg_start;
		logic div_step;
		logic emit;
	} cmd_t;

endpackage

>>> rtl/core/gsfp_ctrl.sv
// Sequencer for the foothold planner: input handshake, arithmetic op
// sequence, per-leg loop, remainder iterations and output valid.
// Depends on gsfp_pkg.
module gsfp_ctrl #(
	parameter int LEG_COUNT = gsfp_pkg::LEG_COUNT_DEF,
	localparam int LegW = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  logic            fast_ok,
	output gsfp_pkg::cmd_t  cmd,
	output logic [LegW-1:0] leg
);
	import gsfp_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ARITH = 3'd1;
	localparam logic [2:0] ST_LEG   = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	localparam logic [DIV_CNT_W-1:0] DivLast = DIV_CNT_W'(SUM_W - 1);
	localparam logic [LegW-1:0]      LegLast = LegW'(LEG_COUNT - 1);

	logic [2:0]           state_q, state_d;
	op_t                  op_q;
	logic [LegW-1:0]      leg_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;
	logic                 leg_last;

	assign leg_last  = (leg_q == LegLast);
	assign leg       = leg_q;
	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		cmd.op  = OP_NONE;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_ARITH;
				end
			end
			ST_ARITH: begin
				cmd.op = op_q;
				if (op_q == OP_OY) begin
					state_d = ST_LEG;
				end
			end
			ST_LEG: begin
				cmd.leg_start = 1'b1;
				state_d       = fast_ok ? ST_EMIT : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DivLast) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.emit = 1'b1;
					state_d  = leg_last ? ST_IDLE : ST_LEG;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_NONE;
			leg_q       <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_in) begin
				op_q  <= OP_CX;
				leg_q <= '0;
			end else if (state_q == ST_ARITH && op_q != OP_OY) begin
				op_q <= op_t'(op_q + 4'd1);
			end
			if (cmd.emit && !leg_last) begin
				leg_q <= leg_q + LegW'(1);
			end
			if (cmd.leg_start) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while stalled");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_cnt_q <= DivLast))
		else $error("remainder iteration count overrun");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && leg_last) |=> (state_q == ST_IDLE))
		else $error("no return to idle after last leg");

	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |=> (state_q == ST_ARITH && op_q == OP_CX && leg_q == '0))
		else $error("item start not set up");

endmodule

>>> rtl/core/gsfp_dp.sv
// Datapath for the foothold planner: configuration registers, shared
// multiplier with accumulator, phase counters, bit-serial remainder unit and
// result register. Depends on gsfp_pkg.
module gsfp_dp #(
	parameter int LEG_COUNT = gsfp_pkg::LEG_COUNT_DEF,
	localparam int LegW = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [gsfp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gsfp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  gsfp_pkg::cmd_t                      cmd,
	input  logic [LegW-1:0]                     leg,
	output logic                                fast_ok,
	input  logic                                walk_mode,
	input  logic signed [23:0]                  vel_world_x,
	input  logic signed [23:0]                  vel_world_y,
	input  logic signed [15:0]                  yaw_cos,
	input  logic signed [15:0]                  yaw_sin,
	input  logic signed [23:0]                  want_vel_x,
	input  logic signed [23:0]                  want_vel_y,
	output logic [1:0]                          leg_index,
	output logic                                in_contact,
	output logic [15:0]                         leg_phase,
	output logic signed [15:0]                  offset_x,
	output logic signed [15:0]                  offset_y,
	output logic                                last_leg
);
	import gsfp_pkg::*;

	localparam logic [LegW-1:0] LegLast = LegW'(LEG_COUNT - 1);

	function automatic logic [15:0] clamp_mag(input logic signed [29:0] v,
			input logic [14:0] lim);
		logic signed [29:0] lim_s;
		logic signed [29:0] res;
		lim_s = signed'({15'd0, lim});
		if (v > lim_s) begin
			res = lim_s;
		end else if (v < -lim_s) begin
			res = -lim_s;
		end else begin
			res = v;
		end
		return res[15:0];
	endfunction

	logic [15:0] cfg_period_q, cfg_swing_q, cfg_step_q;
	logic [63:0] cfg_offsets_q;
	logic [15:0] cfg_gain_q, cfg_hst_q;
	logic [14:0] cfg_limx_q, cfg_limy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_period_q  <= GAIT_PERIOD_RST;
			cfg_swing_q   <= SWING_COUNT_RST;
			cfg_step_q    <= COUNTER_STEP_RST;
			cfg_offsets_q <= '0;
			cfg_gain_q    <= '0;
			cfg_hst_q     <= '0;
			cfg_limx_q    <= '0;
			cfg_limy_q    <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_GAIT_PERIOD:     cfg_period_q  <= cfg_data[15:0];
				REG_SWING_COUNT:     cfg_swing_q   <= cfg_data[15:0];
				REG_COUNTER_STEP:    cfg_step_q    <= cfg_data[15:0];
				REG_PHASE_OFFSETS:   cfg_offsets_q <= cfg_data[63:0];
				REG_VELOCITY_GAIN:   cfg_gain_q    <= cfg_data[15:0];
				REG_HALF_SWING_TIME: cfg_hst_q     <= cfg_data[15:0];
				REG_LIMIT_X:         cfg_limx_q    <= cfg_data[14:0];
				REG_LIMIT_Y:         cfg_limy_q    <= cfg_data[14:0];
			endcase
		end
	end

	logic               walk_q;
	logic signed [23:0] vx_q, vy_q, wx_q, wy_q;
	logic signed [15:0] c_q, s_q;
	logic signed [27:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [44:0] p_q;
	logic signed [45:0] acc_q;
	logic signed [45:0] p_ext, acc_add, acc_sub, rnd14_sum, rnd16_sum;
	logic signed [26:0] bx_q, by_q, rnd14;
	logic signed [29:0] rnd16;
	logic signed [27:0] dif_q, dif_x, dif_y;
	logic signed [15:0] ox_q, oy_q;

	assign p_ext     = {p_q[44], p_q};
	assign acc_add   = acc_q + p_ext;
	assign acc_sub   = acc_q - p_ext;
	assign rnd14_sum = acc_q + 46'sd8192;
	assign rnd14     = rnd14_sum[40:14];
	assign rnd16_sum = acc_q + 46'sd32768;
	assign rnd16     = rnd16_sum[45:16];
	assign dif_x     = {bx_q[26], bx_q} - {{4{wx_q[23]}}, wx_q};
	assign dif_y     = {by_q[26], by_q} - {{4{wy_q[23]}}, wy_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_CX: begin
				mul_a = {{4{vx_q[23]}}, vx_q};
				mul_b = {c_q[15], c_q};
			end
			OP_SY: begin
				mul_a = {{4{vy_q[23]}}, vy_q};
				mul_b = {s_q[15], s_q};
			end
			OP_CY: begin
				mul_a = {{4{vy_q[23]}}, vy_q};
				mul_b = {c_q[15], c_q};
			end
			OP_SX: begin
				mul_a = {{4{vx_q[23]}}, vx_q};
				mul_b = {s_q[15], s_q};
			end
			OP_GX, OP_GY: begin
				mul_a = dif_q;
				mul_b = signed'({1'b0, cfg_gain_q});
			end
			OP_HX: begin
				mul_a = {{4{wx_q[23]}}, wx_q};
				mul_b = signed'({1'b0, cfg_hst_q});
			end
			OP_HY: begin
				mul_a = {{4{wy_q[23]}}, wy_q};
				mul_b = signed'({1'b0, cfg_hst_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
		if (cmd.load_in) begin
			walk_q <= walk_mode;
			vx_q   <= vel_world_x;
			vy_q   <= vel_world_y;
			c_q    <= yaw_cos;
			s_q    <= yaw_sin;
			wx_q   <= want_vel_x;
			wy_q   <= want_vel_y;
		end
		unique case (cmd.op)
			OP_SY: acc_q <= p_ext;
			OP_CY: acc_q <= acc_add;
			OP_SX: begin
				bx_q  <= rnd14;
				acc_q <= p_ext;
			end
			OP_BY: acc_q <= acc_sub;
			OP_DX: begin
				by_q  <= rnd14;
				dif_q <= dif_x;
			end
			OP_GX: dif_q <= dif_y;
			OP_HX: acc_q <= p_ext;
			OP_GY: acc_q <= acc_add;
			OP_HY: begin
				ox_q  <= clamp_mag(rnd16, cfg_limx_q);
				acc_q <= p_ext;
			end
			OP_FY: acc_q <= acc_add;
			OP_OY: oy_q  <= clamp_mag(rnd16, cfg_limy_q);
			default: begin
			end
		endcase
	end

	logic [15:0]      phase_q [LEG_COUNT];
	logic [7:0]       leg_wide;
	logic [15:0]      reload;
	logic [SUM_W-1:0] sum_w, sum_q;
	logic [SUM_W:0]   diff_w;
	logic             sum_lt, diff_lt;
	logic [15:0]      fast_res, res_q, div_res;
	logic [SUM_W-1:0] div_t;

	assign leg_wide = 8'(leg);

	always_comb begin
		reload = '0;
		for (int k = 0; k < OFFSET_SLOTS; k++) begin
			if (leg_wide == 8'(k)) begin
				reload = cfg_offsets_q[16*k +: 16];
			end
		end
	end

	assign sum_w   = {1'b0, phase_q[leg]} + {1'b0, cfg_step_q};
	assign diff_w  = {1'b0, sum_w} - {2'b0, cfg_period_q};
	assign sum_lt  = (sum_w < {1'b0, cfg_period_q});
	assign diff_lt = !diff_w[SUM_W] && (diff_w[SUM_W-1:0] < {1'b0, cfg_period_q});
	assign fast_ok = !walk_q || (cfg_period_q == '0) || sum_lt || diff_lt;

	always_comb begin
		priority if (!walk_q) begin
			fast_res = reload;
		end else if (cfg_period_q == '0 || sum_lt) begin
			fast_res = sum_w[15:0];
		end else begin
			fast_res = diff_w[15:0];
		end
	end

	assign div_t   = {res_q, sum_q[SUM_W-1]};
	assign div_res = (div_t >= {1'b0, cfg_period_q}) ?
		16'(div_t - {1'b0, cfg_period_q}) : div_t[15:0];

	always_ff @(posedge clk) begin
		if (cmd.leg_start) begin
			sum_q <= sum_w;
			res_q <= fast_ok ? fast_res : '0;
		end else if (cmd.div_step) begin
			sum_q <= sum_q << 1;
			res_q <= div_res;
		end
		if (cmd.emit) begin
			leg_index  <= leg_wide[1:0];
			in_contact <= !walk_q || (res_q <= cfg_swing_q);
			leg_phase  <= res_q;
			offset_x   <= ox_q;
			offset_y   <= oy_q;
			last_leg   <= (leg == LegLast);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LEG_COUNT; k++) begin
				phase_q[k] <= '0;
			end
		end else if (cmd.emit) begin
			phase_q[leg] <= res_q;
		end
	end

	a_phase_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && walk_q && cfg_period_q != '0) |-> (res_q < cfg_period_q))
		else $error("walking phase not below gait period");

endmodule

>>> rtl/core/gait_scheduler_foothold_planner_core.sv
// Gait scheduler and foothold planner, top level. Takes one control tick per
// item and gives one result item per leg, leg 0 first. Depends on gsfp_pkg,
// gsfp_ctrl and gsfp_dp.
//
// An item is taken only while the block is idle. The foothold arithmetic
// runs through one shared 28x17 multiplier and accumulator, one op after
// another; then each leg takes a phase update and a result load when the
// block is not walking, the gait period is zero, or the phase plus step is
// below twice the gait period, and runs the bit-serial remainder unit in
// between when it is not. A result waits while the result register is valid
// and out_stall is high. Configuration is to be written only while the block
// is idle; the block itself does not enforce this.
module gait_scheduler_foothold_planner_core #(
	parameter int LEG_COUNT = gsfp_pkg::LEG_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [gsfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gsfp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            walk_mode,
	input  logic signed [23:0]              vel_world_x,
	input  logic signed [23:0]              vel_world_y,
	input  logic signed [15:0]              yaw_cos,
	input  logic signed [15:0]              yaw_sin,
	input  logic signed [23:0]              want_vel_x,
	input  logic signed [23:0]              want_vel_y,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      leg_index,
	output logic                            in_contact,
	output logic [15:0]                     leg_phase,
	output logic signed [15:0]              offset_x,
	output logic signed [15:0]              offset_y,
	output logic                            last_leg
);
	import gsfp_pkg::*;

	localparam int LegW = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1;

	cmd_t            cmd;
	logic [LegW-1:0] leg;
	logic            fast_ok;

	gsfp_ctrl #(
		.LEG_COUNT(LEG_COUNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.fast_ok   (fast_ok),
		.cmd       (cmd),
		.leg       (leg)
	);

	gsfp_dp #(
		.LEG_COUNT(LEG_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.leg         (leg),
		.fast_ok     (fast_ok),
		.walk_mode   (walk_mode),
		.vel_world_x (vel_world_x),
		.vel_world_y (vel_world_y),
		.yaw_cos     (yaw_cos),
		.yaw_sin     (yaw_sin),
		.want_vel_x  (want_vel_x),
		.want_vel_y  (want_vel_y),
		.leg_index   (leg_index),
		.in_contact  (in_contact),
		.leg_phase   (leg_phase),
		.offset_x    (offset_x),
		.offset_y    (offset_y),
		.last_leg    (last_leg)
	);

endmodule
